@@ rtl/bmhq_pkg.sv @@
// ----------------------------------------------------------------------------
// bmhq_pkg: shared definitions for the min-priority queue core
// Sizes, command and status codes, and the control word broadcast to the
// row of sorted storage cells.
// ----------------------------------------------------------------------------
package bmhq_pkg;

   localparam int CAPACITY       = 64;
   localparam int VALUE_BITS     = 16;
   localparam int COUNT_BITS     = $clog2(CAPACITY + 1);
   localparam int LIMIT_BITS     = 7;
   localparam int OUT_COUNT_BITS = 7;
   localparam int CMP_BITS       = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 7'd64;

   typedef enum logic [1:0] {
      CMD_INSERT  = 2'd0,
      CMD_EXTRACT = 2'd1,
      CMD_PEEK    = 2'd2,
      CMD_CLEAR   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD    = 2'd0,
      CELL_INSERT  = 2'd1,
      CELL_EXTRACT = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type           op;
      logic [VALUE_BITS-1:0] key;
   } cell_ctrl_type;

endpackage

@@ rtl/bmhq_if.sv @@
// ----------------------------------------------------------------------------
// bmhq request and response channels
// Valid/ready channels carrying the queue requests and their results.
// ----------------------------------------------------------------------------
interface bmhq_req_if;
   import bmhq_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [1:0]            command;
   logic [VALUE_BITS-1:0] key_value;

   modport source (output valid, output command, output key_value, input ready);
   modport sink   (input valid, input command, input key_value, output ready);
endinterface

interface bmhq_rsp_if;
   import bmhq_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [VALUE_BITS-1:0]     result_value;
   logic [1:0]                status;
   logic [OUT_COUNT_BITS-1:0] entry_count;

   modport source (output valid, output result_value, output status, output entry_count,
                   input ready);
   modport sink   (input valid, input result_value, input status, input entry_count,
                   output ready);
endinterface

@@ rtl/bmhq_cell.sv @@
// ----------------------------------------------------------------------------
// bmhq_cell: one slot of the sorted storage row
// Holds one value; on insert takes the key or its left neighbor's value,
// on extract takes its right neighbor's value.
// ----------------------------------------------------------------------------
module bmhq_cell (
   input  logic                            clock,
   input  bmhq_pkg::cell_ctrl_type         ctrl,
   input  logic                            active,
   input  logic                            left_lt,
   input  logic [bmhq_pkg::VALUE_BITS-1:0] left_value,
   input  logic [bmhq_pkg::VALUE_BITS-1:0] right_value,
   output logic                            lt_out,
   output logic [bmhq_pkg::VALUE_BITS-1:0] value_out
);
   import bmhq_pkg::*;

   logic [VALUE_BITS-1:0] value_ff;
   logic [VALUE_BITS-1:0] value_in;

   // key lands at or left of this slot when the slot is empty or larger
   assign lt_out    = !active || (ctrl.key < value_ff);
   assign value_out = value_ff;

   always_comb begin
      unique case (ctrl.op)
         CELL_INSERT:  value_in = lt_out ? (left_lt ? left_value : ctrl.key) : value_ff;
         CELL_EXTRACT: value_in = right_value;
         default:      value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

@@ rtl/binary_min_heap_queue_core.sv @@
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core: min-priority queue on a row of sorted cells
// Result: a request's result is loaded into the response register on acceptance.
// Throughput: one request per cycle while responses drain; every cell
// updates from its neighbors in one parallel shift, so no command walks tree levels.
// Reset: entry count goes to zero and the capacity limit to 64; cell
// contents are left as they are, and no clearing pass is needed.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [6:0]        csr_write_data,
   bmhq_req_if.sink          req_chan,
   bmhq_rsp_if.source        rsp_chan
);
   import bmhq_pkg::*;

   // Row of cells kept sorted ascending; cell 0 always holds the minimum.
   logic [VALUE_BITS-1:0] cell_value [CAPACITY];
   logic                  cell_lt    [CAPACITY];
   cell_ctrl_type         cell_ctrl;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [LIMIT_BITS-1:0] limit_ff;

   logic                      rsp_valid_ff;
   logic [VALUE_BITS-1:0]     rsp_value_ff, rsp_value_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [OUT_COUNT_BITS-1:0] rsp_count_ff;

   logic    req_fire;
   logic    rsp_fire;
   logic    is_full;
   logic    is_empty;
   cmd_type cmd;

   // Advance whenever the output register is free or being drained; hold
   // off every request while reset is high.
   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;
   assign cmd            = cmd_type'(req_chan.command);

   assign is_empty = (count_ff == '0);
   // A limit above the capacity saturates; a limit of zero keeps it full.
   assign is_full  = (CMP_BITS'(count_ff) >= CMP_BITS'(limit_ff))
                  || (count_ff >= COUNT_BITS'(CAPACITY));

   // Decode the request into the cell broadcast, next count and result.
   always_comb begin
      cell_ctrl.op  = CELL_HOLD;
      cell_ctrl.key = req_chan.key_value;
      count_in      = count_ff;
      rsp_value_in  = is_empty ? '0 : cell_value[0];
      rsp_status_in = STATUS_OK;
      unique case (cmd)
         CMD_INSERT: begin
            if (is_full) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               cell_ctrl.op = CELL_INSERT;
               count_in     = count_ff + 1'b1;
               // New minimum is the key unless the root is no larger.
               if (is_empty || (req_chan.key_value < cell_value[0])) begin
                  rsp_value_in = req_chan.key_value;
               end
            end
         end
         CMD_EXTRACT: begin
            if (is_empty) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               cell_ctrl.op = CELL_EXTRACT;
               count_in     = count_ff - 1'b1;
            end
         end
         CMD_PEEK: begin
            if (is_empty) begin
               rsp_status_in = STATUS_EMPTY;
            end
         end
         CMD_CLEAR: begin
            count_in     = '0;
            rsp_value_in = '0;
         end
         default: begin
            rsp_status_in = STATUS_OK;
         end
      endcase
      // Hold the row unless a request is actually taken.
      if (!req_fire) begin
         cell_ctrl.op = CELL_HOLD;
      end
   end

   // Cell row: each cell sees its left and right neighbor.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                  left_lt;
      logic [VALUE_BITS-1:0] left_value;
      logic [VALUE_BITS-1:0] right_value;

      if (i == 0) begin : g_head
         assign left_lt    = 1'b0;
         assign left_value = cell_value[i];
      end else begin : g_body
         assign left_lt    = cell_lt[i-1];
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_value = cell_value[i];
      end else begin : g_link
         assign right_value = cell_value[i+1];
      end

      bmhq_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .active      (count_ff > COUNT_BITS'(i)),
         .left_lt     (left_lt),
         .left_value  (left_value),
         .right_value (right_value),
         .lt_out      (cell_lt[i]),
         .value_out   (cell_value[i])
      );
   end

   // Control registers: count, limit, response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
         if (req_fire) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload: load on accept, hold while stalled.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= OUT_COUNT_BITS'(count_in);
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_value = rsp_value_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.entry_count  = rsp_count_ff;

   // Count never runs past the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(CAPACITY))
      else $error("entry count exceeds capacity");

   // A taken clear empties the queue.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_fire && cmd == CMD_CLEAR) |=> (count_ff == '0))
      else $error("clear did not empty the queue");

   // The row stays sorted at its head.
   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= COUNT_BITS'(2)) |-> !(cell_value[1] < cell_value[0]))
      else $error("cell row out of order");

   // A refused insert leaves the count unchanged.
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (req_fire && cmd == CMD_INSERT && is_full) |=> (count_ff == $past(count_ff)))
      else $error("refused insert changed the count");

endmodule

@@ tb/binary_min_heap_queue_core_test.sv @@
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core_test: self-checking bench for the priority queue
// Drives insert, extract, peek and clear requests through the valid/ready
// request channel and checks every response against a shadow min-heap kept
// in the bench. Covers the capacity limit register at its extremes,
// back-pressure that stalls the core, and random traffic with random idling.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_core_test;
   import bmhq_pkg::*;

   // Cycle budget for the whole run.
   localparam int RUN_LIMIT   = 400000;
   // Cycles a drain may take before the bench gives up waiting.
   localparam int DRAIN_LIMIT = 3000;
   // Print at most this many mismatch lines; keep counting past it.
   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      logic [VALUE_BITS-1:0]     value;
      status_type                status;
      logic [OUT_COUNT_BITS-1:0] count;
   } heap_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_enable;
   logic [LIMIT_BITS-1:0] csr_write_data;

   bmhq_req_if req_bus ();
   bmhq_rsp_if rsp_bus ();

   binary_min_heap_queue_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus)
   );

   // Shadow copy of the heap: array, fill count and the limit register.
   logic [VALUE_BITS-1:0] shadow_heap [CAPACITY];
   int unsigned           shadow_fill  = 0;
   logic [LIMIT_BITS-1:0] shadow_limit = LIMIT_RESET;

   // Results owed by the core, oldest first.
   heap_result_type awaited_heap_results [$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned stall_left     = 0;
   bit          idle_on        = 1'b1;

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Count down a long receiver hold-off requested by a test.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end
   end

   // Hard stop: a hung handshake or a lost response ends up here.
   initial begin : watchdog
      wait (cycle_count >= RUN_LIMIT);
      $display("binary_min_heap_queue_core verification failed");
      $finish;
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
      end
      mismatch_count++;
   endtask

   // Apply one request to the shadow heap and return the response it must
   // produce. Sift up on insert, sift the last entry down on extract; an
   // entry only moves past a strictly larger parent or a strictly smaller child.
   function automatic heap_result_type heap_apply_command(cmd_type cmd,
                                                          logic [VALUE_BITS-1:0] key);
      heap_result_type       res;
      int unsigned           lim;
      int unsigned           i;
      int unsigned           parent;
      int unsigned           child;
      logic [VALUE_BITS-1:0] last;
      bit                    done;
      res.value  = '0;
      res.status = STATUS_OK;
      lim = (int'(shadow_limit) > CAPACITY) ? CAPACITY : int'(shadow_limit);
      case (cmd)
         CMD_INSERT: begin
            if (shadow_fill >= lim || shadow_fill >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else begin
               i = shadow_fill;
               done = 1'b0;
               while (!done && i > 0) begin
                  parent = (i - 1) / 2;
                  if (shadow_heap[parent] <= key) begin
                     done = 1'b1;
                  end else begin
                     shadow_heap[i] = shadow_heap[parent];
                     i = parent;
                  end
               end
               shadow_heap[i] = key;
               shadow_fill++;
            end
            if (shadow_fill > 0) begin
               res.value = shadow_heap[0];
            end
         end
         CMD_EXTRACT: begin
            if (shadow_fill == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.value = shadow_heap[0];
               shadow_fill--;
               last = shadow_heap[shadow_fill];
               i = 0;
               done = 1'b0;
               while (!done && 2 * i + 1 < shadow_fill) begin
                  child = 2 * i + 1;
                  if (child + 1 < shadow_fill && shadow_heap[child + 1] < shadow_heap[child]) begin
                     child++;
                  end
                  if (last > shadow_heap[child]) begin
                     shadow_heap[i] = shadow_heap[child];
                     i = child;
                  end else begin
                     done = 1'b1;
                  end
               end
               if (shadow_fill > 0) begin
                  shadow_heap[i] = last;
               end
            end
         end
         CMD_PEEK: begin
            if (shadow_fill == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.value = shadow_heap[0];
            end
         end
         default: begin
            shadow_fill = 0;
         end
      endcase
      res.count = shadow_fill[OUT_COUNT_BITS-1:0];
      return res;
   endfunction

   // Offer one request and hold it until the core takes it. Valid stays
   // high after acceptance so a back-to-back request can be offered straight away.
   task automatic send_request(cmd_type cmd, logic [VALUE_BITS-1:0] key);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.command   <= cmd;
      req_bus.key_value <= key;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      awaited_heap_results.push_back(heap_apply_command(cmd, key));
   endtask

   // Drop valid and wait until every owed response has come back, or until DRAIN_LIMIT runs out.
   task automatic wait_for_drain();
      int unsigned waited;
      waited = 0;
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (awaited_heap_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   // Write the capacity limit while the core is idle.
   task automatic write_limit(logic [LIMIT_BITS-1:0] value);
      wait_for_drain();
      repeat (3) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shadow_limit = value;
   endtask

   // Bias keys toward the extremes and a narrow band that forces ties.
   function automatic logic [VALUE_BITS-1:0] draw_key();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0:       return '0;
         1:       return '1;
         2, 3:    return VALUE_BITS'($urandom_range(0, 7));
         default: return VALUE_BITS'($urandom);
      endcase
   endfunction

   function automatic cmd_type draw_command(int unsigned ins_pct, int unsigned ext_pct,
                                            int unsigned peek_pct);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < ins_pct) return CMD_INSERT;
      if (pick < ins_pct + ext_pct) return CMD_EXTRACT;
      if (pick < ins_pct + ext_pct + peek_pct) return CMD_PEEK;
      return CMD_CLEAR;
   endfunction

   // Check each response against the oldest owed result.
   always @(posedge clock) begin : response_check
      heap_result_type want;
      if (reset !== 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (awaited_heap_results.size() == 0) begin
            report_mismatch("response with nothing owed, value",
                            32'(rsp_bus.result_value), 32'd0);
         end else begin
            want = awaited_heap_results.pop_front();
            if (rsp_bus.result_value !== want.value) begin
               report_mismatch("result_value", 32'(rsp_bus.result_value), 32'(want.value));
            end
            if (rsp_bus.status !== want.status) begin
               report_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
            end
            if (rsp_bus.entry_count !== want.count) begin
               report_mismatch("entry_count", 32'(rsp_bus.entry_count), 32'(want.count));
            end
         end
      end
   end

   // Response sink: when idling is on, hold ready low for a random gap before
   // each response, and keep it low for as long as a requested stall lasts.
   initial begin : response_sink
      int unsigned gap;
      forever begin
         gap = idle_on ? $urandom_range(0, 5) : 0;
         if (gap > 0 || stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
            while (stall_left > 0) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1));
      end
   end

   // Empty heap handling, extremes of the key, ties, and clear.
   task automatic test_directed();
      send_request(CMD_EXTRACT, 16'h1234);   // extract from empty heap
      send_request(CMD_PEEK, 16'hFFFF);      // peek on empty heap
      send_request(CMD_INSERT, 16'hFFFF);
      send_request(CMD_INSERT, 16'h0000);
      send_request(CMD_INSERT, 16'h8000);
      send_request(CMD_INSERT, 16'h8000);    // tie with an entry already held
      send_request(CMD_INSERT, 16'h7FFF);
      send_request(CMD_PEEK, 16'h0000);
      send_request(CMD_EXTRACT, 16'h0000);
      send_request(CMD_EXTRACT, 16'hFFFF);
      send_request(CMD_EXTRACT, 16'h0000);
      send_request(CMD_EXTRACT, 16'h0000);
      send_request(CMD_EXTRACT, 16'h0000);
      send_request(CMD_EXTRACT, 16'h0000);   // heap empty again
      send_request(CMD_INSERT, 16'h5555);
      send_request(CMD_INSERT, 16'hAAAA);
      send_request(CMD_INSERT, 16'h0001);
      send_request(CMD_CLEAR, 16'hFFFF);
      send_request(CMD_PEEK, 16'h0000);
      send_request(CMD_EXTRACT, 16'h0000);
      send_request(CMD_CLEAR, 16'h0000);     // clear when already empty
      send_request(CMD_INSERT, 16'hAAAA);
      send_request(CMD_INSERT, 16'h5555);
   endtask

   // Capacity limit at zero, one, saturated, and lowered under the fill.
   task automatic test_capacity_limit();
      write_limit(7'd0);                     // every insert refused
      send_request(CMD_INSERT, 16'h0042);
      send_request(CMD_INSERT, 16'hFFFF);
      send_request(CMD_CLEAR, 16'h0000);
      send_request(CMD_INSERT, 16'h0001);
      send_request(CMD_PEEK, 16'h0000);
      send_request(CMD_EXTRACT, 16'h0000);

      write_limit(7'd1);
      send_request(CMD_INSERT, 16'h1234);
      send_request(CMD_INSERT, 16'h0001);    // refused, reports current minimum
      send_request(CMD_PEEK, 16'h0000);
      send_request(CMD_EXTRACT, 16'h0000);
      send_request(CMD_EXTRACT, 16'h0000);

      write_limit(7'd127);                   // saturates to full capacity
      for (int n = 0; n < CAPACITY; n++) begin
         send_request(CMD_INSERT, draw_key());
      end
      send_request(CMD_INSERT, 16'h0000);    // heap full

      write_limit(7'd10);                    // limit now below the fill count
      send_request(CMD_INSERT, 16'h0000);
      send_request(CMD_PEEK, 16'h0000);
      for (int n = 0; n < CAPACITY - 9; n++) begin
         send_request(CMD_EXTRACT, draw_key());
      end
      send_request(CMD_INSERT, 16'h0003);    // count 9 is under the limit
      send_request(CMD_INSERT, 16'h0004);    // count 10 is not
      send_request(CMD_CLEAR, 16'h0000);
      send_request(CMD_PEEK, 16'h0000);
      write_limit(LIMIT_RESET);
   endtask

   // Hold the response side off long enough that the core stalls its input,
   // pause the sender until every response is back, then send with idling off.
   task automatic test_backpressure();
      idle_on = 1'b1;
      stall_left = 300;
      for (int n = 0; n < 60; n++) begin
         send_request(draw_command(70, 20, 8), draw_key());
      end
      wait_for_drain();
      idle_on = 1'b0;
      for (int n = 0; n < 30; n++) begin
         send_request(draw_command(50, 35, 13), draw_key());
      end
      idle_on = 1'b1;
   endtask

   // Random phases: alternate fill-heavy and drain-heavy mixes over a spread
   // of limits, with idling switched off every other phase.
   task automatic test_random_traffic();
      logic [LIMIT_BITS-1:0] limits [8];
      limits[0] = 7'd64;
      limits[1] = 7'd127;
      limits[2] = 7'd1;
      limits[3] = 7'd0;
      limits[4] = 7'd8;
      limits[5] = 7'd33;
      limits[6] = LIMIT_BITS'($urandom_range(0, 127));
      limits[7] = 7'd64;
      for (int p = 0; p < 8; p++) begin
         write_limit(limits[p]);
         idle_on = (p % 2 == 0);
         for (int n = 0; n < 210; n++) begin
            if (p % 2 == 0) begin
               send_request(draw_command(62, 26, 10), draw_key());
            end else begin
               send_request(draw_command(40, 45, 13), draw_key());
            end
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin : test_sequence
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.command   <= CMD_INSERT;
      req_bus.key_value <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_capacity_limit();
      test_backpressure();
      test_random_traffic();

      // Let the last responses land, then allow the pipeline to settle.
      wait_for_drain();
      repeat (4) @(posedge clock);
      if (awaited_heap_results.size() != 0) begin
         report_mismatch("responses never arrived, count",
                         32'(awaited_heap_results.size()), 32'd0);
      end
      if (mismatch_count == 0) begin
         $display("binary_min_heap_queue_core verification clean");
      end else begin
         $display("binary_min_heap_queue_core verification failed");
      end
      $finish;
   end

endmodule

@@ binary_min_heap_queue_core.f @@
rtl/bmhq_pkg.sv
rtl/bmhq_if.sv
rtl/bmhq_cell.sv
rtl/binary_min_heap_queue_core.sv
tb/binary_min_heap_queue_core_test.sv
